[rtl/core/aci_pkg.sv]
// ----------------------------------------------------------------------------
// aci_pkg
// Shared constants, types and tables for the aerodynamic coefficient
// trilinear interpolator: grid geometry, reciprocals, corner values.
// ----------------------------------------------------------------------------
package aci_pkg;

    // Number formats
    localparam int IN_FRAC_BITS   = 16;
    localparam int COEF_FRAC_BITS = 30;
    localparam int CORNER_BITS    = 30;
    localparam int T_BITS         = 16;

    localparam int IN_W   = 24;
    localparam int C_W    = 31;
    localparam int T_W    = T_BITS + 1;
    localparam int V_W    = (IN_FRAC_BITS + 6 > IN_W + 1) ? IN_FRAC_BITS + 6 : IN_W + 1;
    localparam int D_W    = IN_FRAC_BITS + 4;
    localparam int RCP_W  = 32;
    localparam int PR_W   = D_W + RCP_W;
    localparam int RND_SH = IN_FRAC_BITS + 16;
    localparam int P_W    = PR_W + 1 - RND_SH;
    localparam int M_W    = C_W + 1 + T_W + 1;

    localparam int COEF_SHIFT  = CORNER_BITS - COEF_FRAC_BITS;
    localparam int COEF_RND_SH = (COEF_SHIFT > 0) ? COEF_SHIFT - 1 : 0;

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_BITS;

    // Grid: lowest point and step of each axis, in whole units
    localparam int MACH_LO    = 3;
    localparam int MACH_STEP  = 2;
    localparam int ALPHA_LO   = -15;
    localparam int ALPHA_STEP = 15;
    localparam int BETA_LO    = -6;
    localparam int BETA_STEP  = 6;

    // round(2^32 / step)
    localparam logic [RCP_W-1:0] MACH_RCP  = 32'h8000_0000;
    localparam logic [RCP_W-1:0] ALPHA_RCP = 32'd286331153;
    localparam logic [RCP_W-1:0] BETA_RCP  = 32'd715827883;

    // Pipeline stage numbering
    localparam int ST_CLAMP = 0;
    localparam int ST_MUL   = 1;
    localparam int ST_FRAC  = 2;
    localparam int ST_CORN  = 3;
    localparam int ST_MACH  = 4;
    localparam int ST_ALPHA = 6;
    localparam int ST_BETA  = 8;
    localparam int ST_OUT   = 10;
    localparam int N_STAGES = 11;

    typedef enum logic [1:0] {
        AXIS_MACH,
        AXIS_ALPHA,
        AXIS_BETA
    } t_axis;

    typedef struct packed {
        logic clamp;
        logic mul;
        logic rnd;
    } t_loc_en;

    typedef struct packed {
        logic mul;
        logic add;
    } t_lerp_en;

    // Corner values in Q1.30, indexed [coefficient][mach][alpha][beta].
    localparam logic signed [C_W-1:0] CORNER_TAB [3][3][3][3] = '{
        '{ // lift
            '{ '{9341554, 9341554, 9341554},
               '{128849019, 128849019, 128849019},
               '{248356484, 248356484, 248356484} },
            '{ '{16106127, 16106127, 16106127},
               '{128849019, 128849019, 128849019},
               '{241591910, 241591910, 241591910} },
            '{ '{22870701, 22870701, 22870701},
               '{128849019, 128849019, 128849019},
               '{234827337, 234827337, 234827337} }
        },
        '{ // drag
            '{ '{69202661, 67914170, 69202661},
               '{32963874, 31675384, 32963874},
               '{69202661, 67914170, 69202661} },
            '{ '{72423886, 71135396, 72423886},
               '{36185099, 34896609, 36185099},
               '{72423886, 71135396, 72423886} },
            '{ '{75645112, 74356621, 75645112},
               '{39406325, 38117835, 39406325},
               '{75645112, 74356621, 75645112} }
        },
        '{ // side force
            '{ '{-12884902, 0, 12884902},
               '{-12884902, 0, 12884902},
               '{-12884902, 0, 12884902} },
            '{ '{-12884902, 0, 12884902},
               '{-12884902, 0, 12884902},
               '{-12884902, 0, 12884902} },
            '{ '{-12884902, 0, 12884902},
               '{-12884902, 0, 12884902},
               '{-12884902, 0, 12884902} }
        }
    };

    function automatic logic signed [V_W-1:0] axis_lo(input t_axis axis);
        logic signed [V_W-1:0] res;
        unique case (axis)
            AXIS_MACH:  res = V_W'(MACH_LO * (1 << IN_FRAC_BITS));
            AXIS_ALPHA: res = V_W'(ALPHA_LO * (1 << IN_FRAC_BITS));
            AXIS_BETA:  res = V_W'(BETA_LO * (1 << IN_FRAC_BITS));
            default:    res = V_W'(BETA_LO * (1 << IN_FRAC_BITS));
        endcase
        return res;
    endfunction

    function automatic logic signed [V_W-1:0] axis_step(input t_axis axis);
        logic signed [V_W-1:0] res;
        unique case (axis)
            AXIS_MACH:  res = V_W'(MACH_STEP * (1 << IN_FRAC_BITS));
            AXIS_ALPHA: res = V_W'(ALPHA_STEP * (1 << IN_FRAC_BITS));
            AXIS_BETA:  res = V_W'(BETA_STEP * (1 << IN_FRAC_BITS));
            default:    res = V_W'(BETA_STEP * (1 << IN_FRAC_BITS));
        endcase
        return res;
    endfunction

    function automatic logic [RCP_W-1:0] axis_recip(input t_axis axis);
        logic [RCP_W-1:0] res;
        unique case (axis)
            AXIS_MACH:  res = MACH_RCP;
            AXIS_ALPHA: res = ALPHA_RCP;
            AXIS_BETA:  res = BETA_RCP;
            default:    res = BETA_RCP;
        endcase
        return res;
    endfunction

    function automatic logic signed [C_W-1:0] corner(input logic [1:0] coef,
                                                     input logic [1:0] im,
                                                     input logic [1:0] ia,
                                                     input logic [1:0] ib);
        return CORNER_TAB[coef][im][ia][ib];
    endfunction

    // Rescales a Q1.30 value to the output fraction width, rounding half up.
    function automatic logic signed [C_W-1:0] coef_round(input logic signed [C_W-1:0] x);
        logic signed [C_W:0] y;
        y = {x[C_W-1], x} + ((C_W + 1)'(1) <<< COEF_RND_SH);
        if (COEF_SHIFT == 0) begin
            return x;
        end
        return C_W'(y >>> COEF_SHIFT);
    endfunction

endpackage

[rtl/core/aci_if.sv]
// ----------------------------------------------------------------------------
// aci_query_if / aci_result_if
// Valid/ready channels carrying one query beat and one coefficient beat.
// ----------------------------------------------------------------------------
interface aci_query_if;
    logic               valid;
    logic               ready;
    logic        [23:0] mach_number;
    logic signed [23:0] attack_angle_deg;
    logic signed [23:0] sideslip_angle_deg;

    modport source (output valid, output mach_number, output attack_angle_deg,
                    output sideslip_angle_deg, input ready);
    modport sink   (input valid, input mach_number, input attack_angle_deg,
                    input sideslip_angle_deg, output ready);
endinterface

interface aci_result_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] lift_coef;
    logic signed [30:0] drag_coef;
    logic signed [30:0] side_coef;

    modport source (output valid, output lift_coef, output drag_coef,
                    output side_coef, input ready);
    modport sink   (input valid, input lift_coef, input drag_coef,
                    input side_coef, output ready);
endinterface

[rtl/core/aci_locate.sv]
// ----------------------------------------------------------------------------
// aci_locate
// Three-stage grid locator: clamps one axis value, picks the cell and
// turns the offset into a Q1.16 fraction by a constant-reciprocal multiply.
// ----------------------------------------------------------------------------
module aci_locate import aci_pkg::*; (
    input  logic                  i_clk,
    input  t_axis                 i_axis,
    input  t_loc_en               i_en,
    input  logic signed [V_W-1:0] i_value,
    output logic                  o_idx,
    output logic        [T_W-1:0] o_t
);

    logic signed [V_W-1:0] lo, st, mid, hi, v, diff;
    logic                  n_idx_a;
    logic        [D_W-1:0] n_d;
    logic        [D_W-1:0] r_d;
    logic                  r_idx_a, r_idx_b, r_idx_c;
    logic       [PR_W-1:0] n_prod, r_prod;
    logic         [PR_W:0] rnd_sum;
    logic        [P_W-1:0] q;
    logic        [T_W-1:0] n_t, r_t;

    // Clamp and cell selection. A value on the middle point takes the lower
    // cell with a full fraction.
    always_comb begin
        lo  = axis_lo(i_axis);
        st  = axis_step(i_axis);
        mid = lo + st;
        hi  = mid + st;
        v   = i_value;
        if (v < lo) begin
            v = lo;
        end
        if (v > hi) begin
            v = hi;
        end
        if (v <= mid) begin
            n_idx_a = 1'b0;
            diff    = v - lo;
        end else begin
            n_idx_a = 1'b1;
            diff    = v - mid;
        end
        n_d = diff[D_W-1:0];
    end

    always_comb begin
        n_prod = {{RCP_W{1'b0}}, r_d} * {{D_W{1'b0}}, axis_recip(i_axis)};
    end

    always_comb begin
        rnd_sum = {1'b0, r_prod} + ((PR_W + 1)'(1) << (RND_SH - 1));
        q       = rnd_sum[PR_W:RND_SH];
        if (q > P_W'(T_ONE)) begin
            n_t = T_ONE;
        end else begin
            n_t = q[T_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.clamp) begin
            r_d     <= n_d;
            r_idx_a <= n_idx_a;
        end
        if (i_en.mul) begin
            r_prod  <= n_prod;
            r_idx_b <= r_idx_a;
        end
        if (i_en.rnd) begin
            r_t     <= n_t;
            r_idx_c <= r_idx_b;
        end
    end

    assign o_idx = r_idx_c;
    assign o_t   = r_t;

endmodule

[rtl/core/aci_lerp.sv]
// ----------------------------------------------------------------------------
// aci_lerp
// Two-stage linear interpolation a + round((b - a) * t / 2^16) in Q1.30:
// multiply in the first stage, round and add in the second.
// ----------------------------------------------------------------------------
module aci_lerp import aci_pkg::*; (
    input  logic                  i_clk,
    input  t_lerp_en              i_en,
    input  logic signed [C_W-1:0] i_a,
    input  logic signed [C_W-1:0] i_b,
    input  logic        [T_W-1:0] i_t,
    output logic signed [C_W-1:0] o_y
);

    logic signed   [C_W:0] diff;
    logic signed   [T_W:0] ts;
    logic signed [M_W-1:0] n_prod, r_prod;
    logic signed [M_W-1:0] rnd, shifted;
    logic signed [C_W-1:0] r_a, n_y, r_y;

    always_comb begin
        diff   = {i_b[C_W-1], i_b} - {i_a[C_W-1], i_a};
        ts     = {1'b0, i_t};
        n_prod = diff * ts;
    end

    // The interpolated value lies between the corners, so the low bits of the
    // rounded step are enough.
    always_comb begin
        rnd     = r_prod + (M_W'(1) <<< (T_BITS - 1));
        shifted = rnd >>> T_BITS;
        n_y     = r_a + shifted[C_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_prod <= n_prod;
            r_a    <= i_a;
        end
        if (i_en.add) begin
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

[rtl/core/aero_coefficient_trilinear_interp.sv]
// ----------------------------------------------------------------------------
// aero_coefficient_trilinear_interp
// Lift, drag and side-force coefficient lookup over a 3x3x3 grid of Mach,
// angle of attack and sideslip. The block takes one query beat every clock
// cycle when the output is not held off. Three stages locate the cell and
// fraction of each axis (the middle one is the reciprocal multiplier), one
// stage reads the eight corner values, three levels of two-stage
// interpolators work over Mach, attack angle and sideslip in turn, and a
// last stage rounds into the output register. Each stage stalls only when
// it is full and the one after it is stalled, so empty stages keep taking
// beats while a result waits.
// ----------------------------------------------------------------------------
module aero_coefficient_trilinear_interp import aci_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    aci_query_if.sink    i_query,
    aci_result_if.source o_result
);

    logic [N_STAGES-1:0] r_v;
    logic [N_STAGES-1:0] en;

    logic                  w_im, w_ia, w_ib;
    logic        [T_W-1:0] w_tm, w_ta, w_tb;
    logic signed [V_W-1:0] v_mach, v_alpha, v_beta;

    logic signed [C_W-1:0] n_cor [3][2][2][2];
    logic signed [C_W-1:0] r_cor [3][2][2][2];
    logic        [T_W-1:0] r_tm3, r_ta3, r_tb3;
    logic        [T_W-1:0] r_ta4, r_ta5;
    logic        [T_W-1:0] r_tb4, r_tb5, r_tb6, r_tb7;

    logic signed [C_W-1:0] w_cm [3][2][2];
    logic signed [C_W-1:0] w_ca [3][2];
    logic signed [C_W-1:0] w_cb [3];
    logic signed [C_W-1:0] r_lift, r_drag, r_side;

    t_loc_en  loc_en;
    t_lerp_en mach_en, alpha_en, beta_en;

    // Stall chain: a stage moves on when it is empty or its successor moves.
    always_comb begin
        en[N_STAGES-1] = !r_v[N_STAGES-1] || o_result.ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_query.ready = en[ST_CLAMP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[ST_CLAMP]) begin
                r_v[ST_CLAMP] <= i_query.valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign loc_en   = '{clamp: en[ST_CLAMP], mul: en[ST_MUL], rnd: en[ST_FRAC]};
    assign mach_en  = '{mul: en[ST_MACH], add: en[ST_MACH+1]};
    assign alpha_en = '{mul: en[ST_ALPHA], add: en[ST_ALPHA+1]};
    assign beta_en  = '{mul: en[ST_BETA], add: en[ST_BETA+1]};

    assign v_mach  = $signed({{(V_W - IN_W){1'b0}}, i_query.mach_number});
    assign v_alpha = V_W'(i_query.attack_angle_deg);
    assign v_beta  = V_W'(i_query.sideslip_angle_deg);

    aci_locate u_loc_mach (
        .i_clk   (i_clk),
        .i_axis  (AXIS_MACH),
        .i_en    (loc_en),
        .i_value (v_mach),
        .o_idx   (w_im),
        .o_t     (w_tm)
    );

    aci_locate u_loc_alpha (
        .i_clk   (i_clk),
        .i_axis  (AXIS_ALPHA),
        .i_en    (loc_en),
        .i_value (v_alpha),
        .o_idx   (w_ia),
        .o_t     (w_ta)
    );

    aci_locate u_loc_beta (
        .i_clk   (i_clk),
        .i_axis  (AXIS_BETA),
        .i_en    (loc_en),
        .i_value (v_beta),
        .o_idx   (w_ib),
        .o_t     (w_tb)
    );

    // Corner fetch for the selected cell of all three coefficients.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 2; m++) begin
                for (int a = 0; a < 2; a++) begin
                    for (int b = 0; b < 2; b++) begin
                        n_cor[k][m][a][b] = corner(2'(k),
                                                   {1'b0, w_im} + 2'(m),
                                                   {1'b0, w_ia} + 2'(a),
                                                   {1'b0, w_ib} + 2'(b));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_CORN]) begin
            r_cor <= n_cor;
            r_tm3 <= w_tm;
            r_ta3 <= w_ta;
            r_tb3 <= w_tb;
        end
        if (en[ST_MACH]) begin
            r_ta4 <= r_ta3;
            r_tb4 <= r_tb3;
        end
        if (en[ST_MACH+1]) begin
            r_ta5 <= r_ta4;
            r_tb5 <= r_tb4;
        end
        if (en[ST_ALPHA]) begin
            r_tb6 <= r_tb5;
        end
        if (en[ST_ALPHA+1]) begin
            r_tb7 <= r_tb6;
        end
        if (en[ST_OUT]) begin
            r_lift <= coef_round(w_cb[0]);
            r_drag <= coef_round(w_cb[1]);
            r_side <= coef_round(w_cb[2]);
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_coef
        for (genvar a = 0; a < 2; a++) begin : g_ma
            for (genvar b = 0; b < 2; b++) begin : g_mb
                aci_lerp u_mach (
                    .i_clk (i_clk),
                    .i_en  (mach_en),
                    .i_a   (r_cor[k][0][a][b]),
                    .i_b   (r_cor[k][1][a][b]),
                    .i_t   (r_tm3),
                    .o_y   (w_cm[k][a][b])
                );
            end
        end
        for (genvar b = 0; b < 2; b++) begin : g_ab
            aci_lerp u_alpha (
                .i_clk (i_clk),
                .i_en  (alpha_en),
                .i_a   (w_cm[k][0][b]),
                .i_b   (w_cm[k][1][b]),
                .i_t   (r_ta5),
                .o_y   (w_ca[k][b])
            );
        end
        aci_lerp u_beta (
            .i_clk (i_clk),
            .i_en  (beta_en),
            .i_a   (w_ca[k][0]),
            .i_b   (w_ca[k][1]),
            .i_t   (r_tb7),
            .o_y   (w_cb[k])
        );
    end

    assign o_result.valid     = r_v[ST_OUT];
    assign o_result.lift_coef = r_lift;
    assign o_result.drag_coef = r_drag;
    assign o_result.side_coef = r_side;

    // An accepted beat always lands in the first stage.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_query.valid && i_query.ready |=> r_v[ST_CLAMP])
        else $error("accepted query beat not captured");

    // Fractions never exceed one.
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[ST_FRAC] |-> (w_tm <= T_ONE) && (w_ta <= T_ONE) && (w_tb <= T_ONE))
        else $error("cell fraction above one");

    // A held corner stage keeps its beat and its Mach and sideslip fractions.
    a_corner_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[ST_CORN] && !en[ST_MACH] |=> r_v[ST_CORN] && $stable(r_tm3)
                                         && $stable(r_tb3))
        else $error("stalled corner stage lost its beat");

    // Lift does not depend on sideslip, so both beta corners must agree.
    a_lift_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[ST_CORN] |-> r_cor[0][0][0][0] == r_cor[0][0][0][1])
        else $error("lift corners differ across sideslip");

endmodule

[tb/aero_coefficient_trilinear_interp_tb.sv]
// ----------------------------------------------------------------------------
// aero_coefficient_trilinear_interp_tb
// Drives Mach, attack-angle and sideslip queries into the coefficient
// interpolator and checks every lift, drag and side-force beat against a
// predictor of the clamped, fixed-point trilinear interpolation. Directed
// grid and boundary queries come first, then random queries with bursts of
// idling on both channels, a long output hold-off, a full drain pause and a
// final stretch at full rate.
// ----------------------------------------------------------------------------
module aero_coefficient_trilinear_interp_tb import aci_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam time CLK_PERIOD  = 12ns;
    localparam int  RESET_CYCLES = 7;
    localparam int  STALL_LIMIT  = 1000;
    localparam int  DRAIN_CYCLES = 20;
    localparam int  LONG_HOLD    = 150;

    // Number formats and grid, in the block's fixed-point terms
    localparam int     IN_FRAC     = 16;
    localparam int     T_FRAC      = 16;
    localparam int     CORNER_FRAC = 30;
    localparam int     OUT_FRAC    = 30;
    localparam int     OUT_SHIFT   = CORNER_FRAC - OUT_FRAC;
    localparam int     UNIT        = 1 << IN_FRAC;
    localparam int     ANGLE_MAX   = 90 * UNIT;
    localparam longint MACH_GRID_LO    = 3;
    localparam longint MACH_GRID_STEP  = 2;
    localparam longint ALPHA_GRID_LO   = -15;
    localparam longint ALPHA_GRID_STEP = 15;
    localparam longint BETA_GRID_LO    = -6;
    localparam longint BETA_GRID_STEP  = 6;
    localparam longint MACH_RECIP  = 64'd2147483648;
    localparam longint ALPHA_RECIP = 64'd286331153;
    localparam longint BETA_RECIP  = 64'd715827883;

    // Corner values in Q1.30. Lift depends on Mach and attack angle only,
    // drag is symmetric in both angles, side force follows sideslip alone.
    localparam longint LIFT_TAB [3][3] = '{
        '{64'sd9341554,  64'sd128849019, 64'sd248356484},
        '{64'sd16106127, 64'sd128849019, 64'sd241591910},
        '{64'sd22870701, 64'sd128849019, 64'sd234827337}
    };
    // Indexed [mach][attack angle is zero][sideslip is zero].
    localparam longint DRAG_TAB [3][2][2] = '{
        '{'{64'sd69202661, 64'sd67914170}, '{64'sd32963874, 64'sd31675384}},
        '{'{64'sd72423886, 64'sd71135396}, '{64'sd36185099, 64'sd34896609}},
        '{'{64'sd75645112, 64'sd74356621}, '{64'sd39406325, 64'sd38117835}}
    };
    localparam longint SIDE_TAB [3] = '{-64'sd12884902, 64'sd0, 64'sd12884902};

    typedef enum int {
        COEF_LIFT,
        COEF_DRAG,
        COEF_SIDE
    } t_coef_kind;

    typedef struct packed {
        logic        [IN_W-1:0] mach;
        logic signed [IN_W-1:0] alpha;
        logic signed [IN_W-1:0] beta;
    } t_query;

    typedef struct packed {
        logic signed [C_W-1:0] lift;
        logic signed [C_W-1:0] drag;
        logic signed [C_W-1:0] side;
    } t_coef;

    logic i_clk = 1'b0;
    logic i_rst_n;

    aci_query_if  query_bus ();
    aci_result_if result_bus ();

    aero_coefficient_trilinear_interp DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_query  (query_bus),
        .o_result (result_bus)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_coef  coef_expected [$];
    t_coef  coef_front;
    t_query query_seen;
    int     mismatch_count = 0;
    int     quiet_cycles   = 0;
    bit     idling_on      = 1'b1;
    int     sink_hold      = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void locate_axis(input longint v, input longint lo_pt,
                                        input longint step, input longint recip,
                                        output int idx, output longint frac);
        longint lo;
        longint st;
        longint hi;
        longint d;
        longint p;
        lo = lo_pt * UNIT;
        st = step * UNIT;
        hi = lo + 2 * st;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        // A value on the middle point stays in the lower cell at fraction one.
        if (v <= lo + st) begin
            idx = 0;
            d   = v - lo;
        end else begin
            idx = 1;
            d   = v - lo - st;
        end
        p = (d * recip + (64'sd1 <<< (IN_FRAC + 15))) >>> (IN_FRAC + 16);
        if (p > (64'sd1 <<< T_FRAC)) p = 64'sd1 <<< T_FRAC;
        frac = p;
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint t);
        return a + (((b - a) * t + (64'sd1 <<< (T_FRAC - 1))) >>> T_FRAC);
    endfunction

    function automatic longint corner_q30(input t_coef_kind kind, input int m,
                                          input int a, input int b);
        case (kind)
            COEF_LIFT: return LIFT_TAB[m][a];
            COEF_DRAG: return DRAG_TAB[m][a == 1][b == 1];
            default:   return SIDE_TAB[b];
        endcase
    endfunction

    function automatic logic signed [C_W-1:0] interp_coef(input t_coef_kind kind,
            input int im, input int ia, input int ib,
            input longint tm, input longint ta, input longint tb);
        longint c00;
        longint c10;
        longint c01;
        longint c11;
        longint r;
        c00 = blend(corner_q30(kind, im, ia, ib), corner_q30(kind, im + 1, ia, ib), tm);
        c10 = blend(corner_q30(kind, im, ia + 1, ib),
                    corner_q30(kind, im + 1, ia + 1, ib), tm);
        c01 = blend(corner_q30(kind, im, ia, ib + 1),
                    corner_q30(kind, im + 1, ia, ib + 1), tm);
        c11 = blend(corner_q30(kind, im, ia + 1, ib + 1),
                    corner_q30(kind, im + 1, ia + 1, ib + 1), tm);
        r = blend(blend(c00, c10, ta), blend(c01, c11, ta), tb);
        if (OUT_SHIFT > 0) begin
            r = (r + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        end
        return C_W'(r);
    endfunction

    function automatic t_coef predict_coefs(input t_query q);
        int     im;
        int     ia;
        int     ib;
        longint tm;
        longint ta;
        longint tb;
        t_coef  c;
        locate_axis(longint'(q.mach), MACH_GRID_LO, MACH_GRID_STEP, MACH_RECIP, im, tm);
        locate_axis(longint'(q.alpha), ALPHA_GRID_LO, ALPHA_GRID_STEP, ALPHA_RECIP, ia, ta);
        locate_axis(longint'(q.beta), BETA_GRID_LO, BETA_GRID_STEP, BETA_RECIP, ib, tb);
        c.lift = interp_coef(COEF_LIFT, im, ia, ib, tm, ta, tb);
        c.drag = interp_coef(COEF_DRAG, im, ia, ib, tm, ta, tb);
        c.side = interp_coef(COEF_SIDE, im, ia, ib, tm, ta, tb);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Beat monitor, checker and watchdog
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic signed [C_W-1:0] want,
                               input logic signed [C_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (query_bus.valid && query_bus.ready) begin
                query_seen.mach  = query_bus.mach_number;
                query_seen.alpha = query_bus.attack_angle_deg;
                query_seen.beta  = query_bus.sideslip_angle_deg;
                coef_expected    = {coef_expected, predict_coefs(query_seen)};
            end
            if (result_bus.valid && result_bus.ready) begin
                if (coef_expected.size() == 0) begin
                    $error("result beat arrived with no query outstanding");
                    mismatch_count++;
                end else begin
                    coef_front = coef_expected.pop_front();
                    check_field("lift_coef", coef_front.lift, result_bus.lift_coef);
                    check_field("drag_coef", coef_front.drag, result_bus.drag_coef);
                    check_field("side_coef", coef_front.side, result_bus.side_coef);
                end
            end
            if ((query_bus.valid && query_bus.ready) ||
                (result_bus.valid && result_bus.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("aero_coefficient_trilinear_interp_tb failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result-side ready: random stall bursts, or one long hold on request
    // ------------------------------------------------------------------
    initial begin
        int n;
        result_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                n         = sink_hold;
                sink_hold = 0;
                result_bus.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                result_bus.ready <= 1'b1;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                result_bus.ready <= 1'b1;
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Query side
    // ------------------------------------------------------------------
    // Called at a rising edge; returns at the edge where the beat is taken.
    // Valid is left high so that back-to-back beats need no second update.
    task automatic send_query(input logic [IN_W-1:0] mach,
                              input logic signed [IN_W-1:0] alpha,
                              input logic signed [IN_W-1:0] beta);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            query_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        query_bus.valid              <= 1'b1;
        query_bus.mach_number        <= mach;
        query_bus.attack_angle_deg   <= alpha;
        query_bus.sideslip_angle_deg <= beta;
        do @(posedge i_clk); while (!query_bus.ready);
    endtask

    // Directed points are written as whole numbers and cut to the field width.
    task automatic send_grid_point(input int mach, input int alpha, input int beta);
        send_query(IN_W'(mach), IN_W'(alpha), IN_W'(beta));
    endtask

    function automatic t_query random_query();
        t_query q;
        if ($urandom_range(0, 9) < 8) q.mach = IN_W'($urandom_range(0, 9 * UNIT));
        else                          q.mach = IN_W'($urandom());
        if ($urandom_range(0, 9) == 0) q.mach = IN_W'((2 * $urandom_range(0, 2) + 3) * UNIT);

        if ($urandom_range(0, 9) < 8) begin
            q.alpha = IN_W'(int'($urandom_range(0, 40 * UNIT)) - 20 * UNIT);
        end else begin
            q.alpha = IN_W'(int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
        end
        if ($urandom_range(0, 9) == 0) q.alpha = IN_W'((int'($urandom_range(0, 2)) - 1) * 15 * UNIT);

        if ($urandom_range(0, 9) < 8) begin
            q.beta = IN_W'(int'($urandom_range(0, 20 * UNIT)) - 10 * UNIT);
        end else begin
            q.beta = IN_W'(int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
        end
        if ($urandom_range(0, 9) == 0) q.beta = IN_W'((int'($urandom_range(0, 2)) - 1) * 6 * UNIT);
        return q;
    endfunction

    task automatic send_random(input int count);
        t_query q;
        repeat (count) begin
            q = random_query();
            send_query(q.mach, q.alpha, q.beta);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Field extremes, grid points, one step either side of the cell edges.
    task automatic test_grid_edges();
        send_grid_point(0, -ANGLE_MAX, -ANGLE_MAX);
        send_grid_point(32'h00FF_FFFF, ANGLE_MAX, ANGLE_MAX);
        send_grid_point(3 * UNIT, -15 * UNIT, -6 * UNIT);
        send_grid_point(5 * UNIT, 0, 0);
        send_grid_point(7 * UNIT, 15 * UNIT, 6 * UNIT);
        send_grid_point(7 * UNIT, -15 * UNIT, 0);
        send_grid_point(3 * UNIT, 15 * UNIT, 6 * UNIT);
        send_grid_point(5 * UNIT, 0, -6 * UNIT);
        send_grid_point(5 * UNIT - 1, -1, -1);
        send_grid_point(5 * UNIT + 1, 1, 1);
        send_grid_point(3 * UNIT - 1, -15 * UNIT - 1, -6 * UNIT - 1);
        send_grid_point(7 * UNIT + 1, 15 * UNIT + 1, 6 * UNIT + 1);
        send_grid_point(3 * UNIT + 1, -15 * UNIT + 1, -6 * UNIT + 1);
        send_grid_point(7 * UNIT - 1, 15 * UNIT - 1, 6 * UNIT - 1);
        send_grid_point(4 * UNIT + UNIT / 2, -7 * UNIT - UNIT / 2, 3 * UNIT);
        send_grid_point(6 * UNIT, 8 * UNIT, -2 * UNIT);
        send_grid_point(1, -1, 1);
    endtask

    task automatic test_random_sweep();
        send_random(300);
    endtask

    // The output is held off long enough for every stage to fill while
    // the query side keeps offering beats.
    task automatic test_output_hold();
        sink_hold = LONG_HOLD;
        send_random(40);
    endtask

    task automatic test_drain_pause();
        send_random(10);
        query_bus.valid <= 1'b0;
        while (coef_expected.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        send_random(10);
    endtask

    task automatic test_full_rate();
        idling_on = 1'b0;
        send_random(60);
    endtask

    initial begin
        i_rst_n                      = 1'b0;
        query_bus.valid              = 1'b0;
        query_bus.mach_number        = '0;
        query_bus.attack_angle_deg   = '0;
        query_bus.sideslip_angle_deg = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_grid_edges();
        test_random_sweep();
        test_output_hold();
        test_drain_pause();
        test_full_rate();

        query_bus.valid <= 1'b0;
        while (coef_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("aero_coefficient_trilinear_interp_tb passed");
        end else begin
            $display("aero_coefficient_trilinear_interp_tb failed");
        end
        $finish;
    end

endmodule
